// ===== sv/dufp_pkg.sv =====
`default_nettype none

package dufp_pkg;

   // Header bytes that open every frame.
   localparam logic [7:0] HDR_FIRST  = 8'h5A;
   localparam logic [7:0] HDR_SECOND = 8'hA5;

   // Command, length and word count codes that select a message.
   localparam logic [7:0] CMD_UPLOAD  = 8'h83;
   localparam logic [7:0] LEN_KEY     = 8'h06;
   localparam logic [7:0] LEN_WORD    = 8'h05;
   localparam logic [7:0] WORDS_FLOAT = 8'h02;

   // Frame byte positions that matter to the decoder.
   localparam int unsigned POS_LEN       = 2;
   localparam int unsigned POS_CMD       = 3;
   localparam int unsigned POS_ADDR_HI   = 4;
   localparam int unsigned POS_ADDR_LO   = 5;
   localparam int unsigned POS_PAYLOAD   = 6;
   localparam int unsigned PAYLOAD_BYTES = 5;
   localparam int unsigned MIN_MSG_BYTES = 7;
   localparam int unsigned MIN_FLT_BYTES = 11;

   // Message kinds.
   localparam logic [1:0] KIND_KEY   = 2'd0;
   localparam logic [1:0] KIND_WORD  = 2'd1;
   localparam logic [1:0] KIND_FLOAT = 2'd2;
   localparam logic [1:0] KIND_NONE  = 2'd3;

   // One decoded message.
   typedef struct packed {
      logic [1:0]  msg_kind;
      logic [15:0] vp_address;
      logic [15:0] word_value;
      logic [7:0]  key_code;
      logic [31:0] float_bits;
   } msg_type;

endpackage

`default_nettype wire

// ===== sv/display_upload_frame_parser_core.sv =====
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_rx_byte
// rsp       out        rsp_valid/rsp_ready  rsp_msg_kind, rsp_vp_address, rsp_word_value,
//                                           rsp_key_code, rsp_float_bits
//
// One byte is taken per clock cycle while req_ready is high; a message is registered
// into the output register, or the skid entry if rsp stalls, from its frame's last byte.
// The frame state sits in registers and is updated by combinational logic.
// An output register plus one skid entry hold messages; req_ready drops only
// while the skid entry is occupied, i.e. after rsp stalls with two messages.
// Reset is synchronous and clears the frame position and both valid flags.
`default_nettype none

module display_upload_frame_parser_core #(
   parameter int unsigned FRAME_BUFFER_BYTES = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_msg_kind,
   output logic [15:0]      rsp_vp_address,
   output logic [15:0]      rsp_word_value,
   output logic [7:0]       rsp_key_code,
   output logic [31:0]      rsp_float_bits
);
   import dufp_pkg::*;

   localparam logic [6:0] BUF_LIMIT = 7'(FRAME_BUFFER_BYTES);

   // Frame state.
   logic [6:0]  byte_index_ff, byte_index_in;
   logic [7:0]  frame_length_ff, frame_length_in;
   logic [7:0]  command_byte_ff, command_byte_in;
   logic [15:0] address_word_ff, address_word_in;
   logic [7:0]  payload_ff [PAYLOAD_BYTES];
   logic [7:0]  payload_in [PAYLOAD_BYTES];

   // Output register and skid entry.
   logic        rsp_valid_ff, rsp_valid_in;
   logic        skid_valid_ff, skid_valid_in;
   msg_type     out_ff, out_in;
   msg_type     skid_ff, skid_in;

   logic        accept;
   logic        emit;
   logic        out_take;
   logic [6:0]  pos_next;
   logic [8:0]  total;
   msg_type     msg;

   assign accept   = req_valid & req_ready;
   assign out_take = rsp_valid_ff & rsp_ready;
   assign req_ready = ~skid_valid_ff;

   // Frame tracking and message decode for the byte on the input.
   always_comb begin
      byte_index_in   = byte_index_ff;
      frame_length_in = frame_length_ff;
      command_byte_in = command_byte_ff;
      address_word_in = address_word_ff;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         payload_in[i] = payload_ff[i];
      end
      pos_next = byte_index_ff + 7'd1;
      total    = 9'd3 + {1'b0, frame_length_in};
      emit     = 1'b0;
      msg      = '0;
      msg.msg_kind = KIND_NONE;

      if (accept) begin
         if (byte_index_ff == 7'd0) begin
            byte_index_in = (req_rx_byte == HDR_FIRST) ? 7'd1 : 7'd0;
         end else if (byte_index_ff == 7'd1) begin
            byte_index_in = (req_rx_byte == HDR_SECOND) ? 7'd2 : 7'd0;
         end else begin
            // Capture the byte into the field that its position names.
            if (byte_index_ff == 7'(POS_LEN)) begin
               frame_length_in = req_rx_byte;
            end
            if (byte_index_ff == 7'(POS_CMD)) begin
               command_byte_in = req_rx_byte;
            end
            if (byte_index_ff == 7'(POS_ADDR_HI)) begin
               address_word_in[15:8] = req_rx_byte;
            end
            if (byte_index_ff == 7'(POS_ADDR_LO)) begin
               address_word_in[7:0] = req_rx_byte;
            end
            for (int i = 0; i < PAYLOAD_BYTES; i++) begin
               if (byte_index_ff == 7'(POS_PAYLOAD + i)) begin
                  payload_in[i] = req_rx_byte;
               end
            end
            total = 9'd3 + {1'b0, frame_length_in};

            // Oversize drop, frame end, buffer limit drop, or keep counting.
            priority if (pos_next == 7'd3 && total > 9'(FRAME_BUFFER_BYTES)) begin
               byte_index_in = 7'd0;
            end else if ({2'b00, pos_next} >= total) begin
               byte_index_in = 7'd0;
               msg.vp_address = address_word_in;
               if (command_byte_in == CMD_UPLOAD && pos_next >= 7'(MIN_MSG_BYTES)) begin
                  priority if (frame_length_in == LEN_KEY) begin
                     emit           = 1'b1;
                     msg.msg_kind   = KIND_KEY;
                     msg.word_value = {payload_in[0], payload_in[1]};
                     msg.key_code   = payload_in[2];
                  end else if (frame_length_in == LEN_WORD) begin
                     emit           = 1'b1;
                     msg.msg_kind   = KIND_WORD;
                     msg.word_value = {payload_in[0], payload_in[1]};
                  end else if (pos_next >= 7'(MIN_FLT_BYTES)
                               && payload_in[0] == WORDS_FLOAT) begin
                     emit           = 1'b1;
                     msg.msg_kind   = KIND_FLOAT;
                     msg.float_bits = {payload_in[1], payload_in[2],
                                       payload_in[3], payload_in[4]};
                  end else begin
                     emit = 1'b0;
                  end
               end
            end else if (pos_next >= BUF_LIMIT) begin
               byte_index_in = 7'd0;
            end else begin
               byte_index_in = pos_next;
            end
         end
      end
   end

   // Output register with one skid entry behind it.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!rsp_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = emit;
            skid_in       = msg;
         end else begin
            rsp_valid_in = emit;
            out_in       = msg;
         end
      end else if (emit) begin
         skid_valid_in = 1'b1;
         skid_in       = msg;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff   <= 7'd0;
         frame_length_ff <= 8'd0;
         rsp_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         byte_index_ff   <= byte_index_in;
         frame_length_ff <= frame_length_in;
         rsp_valid_ff    <= rsp_valid_in;
         skid_valid_ff   <= skid_valid_in;
      end
   end

   // Frame fields and message payloads need no reset.
   always_ff @(posedge clock) begin
      command_byte_ff <= command_byte_in;
      address_word_ff <= address_word_in;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         payload_ff[i] <= payload_in[i];
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_msg_kind   = out_ff.msg_kind;
   assign rsp_vp_address = out_ff.vp_address;
   assign rsp_word_value = out_ff.word_value;
   assign rsp_key_code   = out_ff.key_code;
   assign rsp_float_bits = out_ff.float_bits;

   // The skid entry is only filled behind a stalled output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid while output register is empty");

   // The frame position never reaches the buffer size.
   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      byte_index_ff < BUF_LIMIT)
      else $error("byte index reached the buffer size");

   // A new message follows an accepted byte.
   a_msg_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept))
      else $error("message appeared without an accepted item");

   // A delivered message always carries a defined kind.
   a_kind_defined: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> out_ff.msg_kind != KIND_NONE)
      else $error("message with undefined kind");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dufp_pkg::*;

   localparam int unsigned FRAME_BUFFER_BYTES = 64;
   localparam int unsigned RANDOM_BYTES = 1550;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned REPORT_LIMIT = 10;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_msg_kind;
   logic [15:0] rsp_vp_address;
   logic [15:0] rsp_word_value;
   logic [7:0]  rsp_key_code;
   logic [31:0] rsp_float_bits;

   // Shadow copy of the parser's frame state.
   logic [6:0]  frame_pos = '0;
   logic [7:0]  frame_len = '0;
   logic [7:0]  cmd_byte = '0;
   logic [15:0] addr_word = '0;
   logic [7:0]  payload [0:PAYLOAD_BYTES-1] = '{default: '0};

   // Messages predicted but not yet seen on rsp.
   msg_type pending_msgs [$];

   int unsigned failures = 0;
   int unsigned bytes_sent = 0;
   int unsigned cycle_count = 0;
   bit          steady = 1'b0;
   int          rsp_hold = 0;

   display_upload_frame_parser_core #(
      .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_msg_kind(rsp_msg_kind),
      .rsp_vp_address(rsp_vp_address),
      .rsp_word_value(rsp_word_value),
      .rsp_key_code(rsp_key_code),
      .rsp_float_bits(rsp_float_bits)
   );

   // Free-running 50 MHz clock.
   initial begin
      clock = 1'b0;
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mostly short idle stretches, now and then a long one.
   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Follows the parser through one accepted byte and queues any message it completes.
   function automatic void parse_byte(input logic [7:0] b);
      int      pos;
      int      total;
      msg_type m;
      if (frame_pos == 0) begin
         if (b == HDR_FIRST) frame_pos = 7'd1;
         return;
      end
      if (frame_pos == 1) begin
         // A bad second byte drops sync and is not taken as a new first byte.
         frame_pos = (b == HDR_SECOND) ? 7'd2 : 7'd0;
         return;
      end

      pos = int'(frame_pos);
      if (pos == POS_LEN) begin
         frame_len = b;
      end else if (pos == POS_CMD) begin
         cmd_byte = b;
      end else if (pos == POS_ADDR_HI) begin
         addr_word[15:8] = b;
      end else if (pos == POS_ADDR_LO) begin
         addr_word[7:0] = b;
      end else if (pos >= POS_PAYLOAD && pos < POS_PAYLOAD + PAYLOAD_BYTES) begin
         payload[pos - POS_PAYLOAD] = b;
      end

      pos = pos + 1;
      frame_pos = 7'(pos);

      // Header and LEN take three bytes ahead of the LEN counted ones.
      total = 3 + int'(frame_len);
      if (pos == POS_LEN + 1 && total > FRAME_BUFFER_BYTES) begin
         frame_pos = '0;
         return;
      end

      if (pos >= total) begin
         m = '0;
         m.vp_address = addr_word;
         if (cmd_byte == CMD_UPLOAD && pos >= MIN_MSG_BYTES) begin
            if (frame_len == LEN_KEY) begin
               m.msg_kind = KIND_KEY;
               m.word_value = {payload[0], payload[1]};
               m.key_code = payload[2];
               pending_msgs.push_back(m);
            end else if (frame_len == LEN_WORD) begin
               m.msg_kind = KIND_WORD;
               m.word_value = {payload[0], payload[1]};
               pending_msgs.push_back(m);
            end else if (pos >= MIN_FLT_BYTES && payload[0] == WORDS_FLOAT) begin
               m.msg_kind = KIND_FLOAT;
               m.float_bits = {payload[1], payload[2], payload[3], payload[4]};
               pending_msgs.push_back(m);
            end
         end
         frame_pos = '0;
         return;
      end

      if (frame_pos >= FRAME_BUFFER_BYTES) frame_pos = '0;
   endfunction

   // Offers one byte, possibly after an idle stretch, and waits until it is taken.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = 0;
      if (!steady && $urandom_range(0, 99) < 30) gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      parse_byte(b);
      bytes_sent++;
   endtask

   // Sends a framed packet; bytes past the payload are random, oversize frames stop at LEN.
   task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd,
                             input logic [15:0] addr, input logic [39:0] data);
      logic [7:0] body [0:7];
      body[0] = cmd;
      body[1] = addr[15:8];
      body[2] = addr[7:0];
      for (int i = 0; i < 5; i++) body[3 + i] = data[39 - 8 * i -: 8];
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);
      send_byte(len);
      if (3 + int'(len) <= FRAME_BUFFER_BYTES) begin
         for (int i = 0; i < int'(len); i++) send_byte(i < 8 ? body[i] : 8'($urandom));
      end
   endtask

   // Holds the sender off until every predicted message has been taken.
   task automatic drain_messages();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_msgs.size() != 0);
   endtask

   task automatic test_header_hunt();
      // Stray bytes, a lone second header byte, and a doubled first header byte.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(HDR_SECOND);
      send_byte(HDR_FIRST);
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);
      send_frame(LEN_KEY, CMD_UPLOAD, 16'hFFFF, 40'hFFFF_FF00_00);
   endtask

   task automatic test_key_event();
      send_frame(LEN_KEY, CMD_UPLOAD, 16'h0000, 40'h0000_00FF_FF);
      // Word count byte of two still gives a key event for this length.
      send_frame(LEN_KEY, CMD_UPLOAD, 16'hA55A, {WORDS_FLOAT, 32'h3412_5678});
   endtask

   task automatic test_word_upload();
      send_frame(LEN_WORD, CMD_UPLOAD, 16'h1234, 40'hFFFF_0000_00);
      send_frame(LEN_WORD, CMD_UPLOAD, 16'hFFFF, {WORDS_FLOAT, 32'h0000_0000});
   endtask

   task automatic test_float_upload();
      send_frame(8'd8, CMD_UPLOAD, 16'hFFFF, {WORDS_FLOAT, 32'hFFFF_FFFF});
      // Largest frame that still fits the buffer, with bytes past the payload.
      send_frame(8'(FRAME_BUFFER_BYTES - 3), CMD_UPLOAD, 16'h0001, {WORDS_FLOAT, 32'h0});
      send_frame(8'd8, CMD_UPLOAD, 16'h0102, {8'h03, 32'h1122_3344});
      send_frame(LEN_KEY, 8'h82, 16'h0304, 40'h1111_1111_11);
   endtask

   task automatic test_short_frames();
      send_frame(8'd0, CMD_UPLOAD, 16'h0, 40'h0);
      send_frame(8'd3, CMD_UPLOAD, 16'hBEEF, 40'h0);
      send_frame(8'd4, CMD_UPLOAD, 16'hBEEF, {WORDS_FLOAT, 32'h0});
      send_frame(8'd7, CMD_UPLOAD, 16'hCAFE, {WORDS_FLOAT, 32'h8000_0001});
   endtask

   task automatic test_oversize();
      send_frame(8'(FRAME_BUFFER_BYTES - 2), CMD_UPLOAD, 16'h0, 40'h0);
      send_frame(8'hFF, CMD_UPLOAD, 16'h0, 40'h0);
      send_frame(LEN_WORD, CMD_UPLOAD, 16'h5AA5, 40'h5AA5_0000_00);
   endtask

   task automatic test_drain_pause();
      send_frame(LEN_KEY, CMD_UPLOAD, 16'h0BAD, 40'hC0DE_7F00_00);
      send_frame(LEN_WORD, CMD_UPLOAD, 16'h0F0F, 40'hF0F0_0000_00);
      drain_messages();
   endtask

   // Mostly well-formed frames with random content, plus noise and broken headers.
   task automatic test_random_traffic();
      int         pick;
      int         n;
      logic [7:0] len;
      logic [7:0] cmd;
      logic [7:0] b;
      while (bytes_sent < RANDOM_BYTES) begin
         if ($urandom_range(0, 99) < 8) steady = !steady;
         if ($urandom_range(0, 199) == 0) drain_messages();
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            send_frame(LEN_KEY, CMD_UPLOAD, 16'($urandom), {8'($urandom), 32'($urandom)});
         end else if (pick < 55) begin
            send_frame(LEN_WORD, CMD_UPLOAD, 16'($urandom), {8'($urandom), 32'($urandom)});
         end else if (pick < 75) begin
            len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(8, FRAME_BUFFER_BYTES - 3))
                                               : 8'($urandom_range(8, 16));
            send_frame(len, CMD_UPLOAD, 16'($urandom), {WORDS_FLOAT, 32'($urandom)});
         end else if (pick < 83) begin
            len = 8'($urandom_range(0, 20));
            b = ($urandom_range(0, 1) == 0) ? WORDS_FLOAT : 8'($urandom);
            send_frame(len, CMD_UPLOAD, 16'($urandom), {b, 32'($urandom)});
         end else if (pick < 88) begin
            cmd = 8'($urandom);
            if (cmd == CMD_UPLOAD) cmd = cmd ^ 8'h01;
            len = ($urandom_range(0, 1) == 0) ? LEN_KEY : LEN_WORD;
            send_frame(len, cmd, 16'($urandom), {8'($urandom), 32'($urandom)});
         end else if (pick < 92) begin
            send_frame(8'($urandom_range(FRAME_BUFFER_BYTES - 2, 255)), CMD_UPLOAD, 16'h0, 40'h0);
         end else if (pick < 96) begin
            b = 8'($urandom);
            if (b == HDR_SECOND) b = HDR_FIRST;
            send_byte(HDR_FIRST);
            send_byte(b);
         end else begin
            n = $urandom_range(1, 4);
            repeat (n) begin
               b = 8'($urandom);
               if (b == HDR_FIRST) b = 8'h00;
               send_byte(b);
            end
         end
      end
      steady = 1'b0;
   endtask

   // Receiver side: ready with random stalls, none started while the steady stretch lasts.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_ready <= 1'b1;
            if (!steady && $urandom_range(0, 99) < 25) rsp_hold = pick_gap();
         end
      end
   end

   // Compares each accepted message with the oldest prediction.
   always @(posedge clock) begin
      msg_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_msgs.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected message: kind %0d addr %h word %h key %h float %h",
                        rsp_msg_kind, rsp_vp_address, rsp_word_value, rsp_key_code,
                        rsp_float_bits);
         end else begin
            want = pending_msgs.pop_front();
            if (rsp_msg_kind !== want.msg_kind || rsp_vp_address !== want.vp_address ||
                rsp_word_value !== want.word_value || rsp_key_code !== want.key_code ||
                rsp_float_bits !== want.float_bits) begin
               failures++;
               if (failures <= REPORT_LIMIT) begin
                  $display("mismatch: expected kind %0d addr %h word %h key %h float %h",
                           want.msg_kind, want.vp_address, want.word_value, want.key_code,
                           want.float_bits);
                  $display("          actual   kind %0d addr %h word %h key %h float %h",
                           rsp_msg_kind, rsp_vp_address, rsp_word_value, rsp_key_code,
                           rsp_float_bits);
               end
            end
         end
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = 8'h00;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_header_hunt();
      test_key_event();
      test_word_upload();
      test_float_upload();
      test_short_frames();
      test_oversize();
      test_drain_pause();
      test_random_traffic();

      // Wait for the last messages, then keep watching for strays.
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_msgs.size() != 0);
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
sv/dufp_pkg.sv
sv/display_upload_frame_parser_core.sv
tb/tb.sv
